>>> rtl/core/ssp_pkg.sv
// Shared types and constants for the section sort and place block.
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int unsigned MAX_SECTIONS_DEF = 64;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_ORDER = 2'd1;

  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SCAN,
    ST_DRAIN,
    ST_ALIGN,
    ST_EMIT
  } ssp_state_t;

  typedef struct packed {
    logic store;
    logic scan_clr;
    logic rd_en;
    logic align;
    logic emit;
  } ssp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic place_end;
    logic out_free;
  } ssp_status_t;

endpackage

>>> rtl/core/ssp_ctrl.sv
// Sequencer for collection, selection scans, alignment and result emission.
`timescale 1ns / 1ps
module ssp_ctrl
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_stall,
  input  ssp_status_t status,
  output ssp_cmd_t    cmd
);

  ssp_state_t state_r;
  ssp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_COLLECT: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            cmd.scan_clr = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (status.scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_ALIGN;
      end
      ST_ALIGN: begin
        cmd.align = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.place_end) begin
            state_nxt = ST_COLLECT;
          end else begin
            cmd.scan_clr = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

endmodule

>>> rtl/core/ssp_dpath.sv
// Section store, minimum-key selection, offset alignment and result register.
`timescale 1ns / 1ps
module ssp_dpath
  import ssp_pkg::*;
#(
  parameter int unsigned MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [31:0]           in_alignment,
  input  logic [31:0]           in_section_bytes,
  input  logic [31:0]           in_trail_zeros,
  input  logic                  in_has_rank,
  input  logic [15:0]           in_rank_value,
  input  ssp_cmd_t              cmd,
  output ssp_status_t           status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [5:0]            out_arrival_index,
  output logic [39:0]           out_start_offset,
  output logic [39:0]           out_total_size,
  output logic                  out_overflow,
  output logic                  out_final_res
);

  localparam int unsigned AW = $clog2(MAX_SECTIONS);
  localparam int unsigned CW = $clog2(MAX_SECTIONS + 1);
  localparam int unsigned MEM_W = 32 + 32 + 32 + 1 + 16;
  localparam int unsigned KEY_W = 17 + 32 + 32 + 32 + AW;

  logic [1:0]           kind_r;
  logic                 rank_en_r;

  logic [MEM_W-1:0]     mem [MAX_SECTIONS];
  logic [MEM_W-1:0]     rd_data_r;
  logic [CW-1:0]        count_r;
  logic                 dropped_r;
  logic [CW-1:0]        rd_idx_r;
  logic [AW-1:0]        cmp_idx_r;
  logic                 cmp_vld_r;
  logic [MAX_SECTIONS-1:0] done_r;
  logic [CW-1:0]        placed_r;

  logic                 best_vld_r;
  logic [KEY_W-1:0]     best_key_r;
  logic [AW-1:0]        best_idx_r;
  logic [31:0]          best_align_r;
  logic [31:0]          best_bytes_r;

  logic [39:0]          run_r;
  logic [39:0]          start_r;
  logic                 out_valid_r;

  logic [31:0]          c_align;
  logic [31:0]          c_bytes;
  logic [31:0]          c_zt;
  logic                 c_hr;
  logic [15:0]          c_rank;
  logic [16:0]          c_rank_key;
  logic [31:0]          c_zt_key;
  logic [KEY_W-1:0]     cand_key;
  logic                 take_cand;
  logic                 final_w;
  logic [39:0]          align_mask;
  logic [39:0]          start_nxt;
  logic [39:0]          end_w;
  logic                 full_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_TEXT;
      rank_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SECTION_KIND: kind_r <= cfg_wdata;
        CFG_RANK_ORDER:   rank_en_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign full_w = (count_r == CW'(MAX_SECTIONS));

  always_ff @(posedge clk) begin
    if (cmd.store && !full_w) begin
      mem[count_r[AW-1:0]] <= {in_alignment, in_section_bytes, in_trail_zeros,
                               in_has_rank, in_rank_value};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  assign {c_align, c_bytes, c_zt, c_hr, c_rank} = rd_data_r;
  assign c_rank_key = (kind_r == KIND_TEXT && rank_en_r) ?
                      {~c_hr, (c_hr ? c_rank : 16'd0)} : 17'd0;
  assign c_zt_key = (kind_r == KIND_DATA) ? c_zt : 32'd0;
  assign cand_key = {c_rank_key, ~c_align, c_zt_key, ~c_bytes, cmp_idx_r};
  assign take_cand = cmp_vld_r && !done_r[cmp_idx_r] &&
                     (!best_vld_r || cand_key < best_key_r);

  assign final_w = (placed_r == count_r - CW'(1));
  assign align_mask = {8'd0, best_align_r - 32'd1};
  assign start_nxt = (best_align_r > 32'd1) ? ((run_r + align_mask) & ~align_mask) : run_r;
  assign end_w = start_r + {8'd0, best_bytes_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      dropped_r <= 1'b0;
      rd_idx_r <= '0;
      cmp_vld_r <= 1'b0;
      done_r <= '0;
      placed_r <= '0;
      best_vld_r <= 1'b0;
      run_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rd_en;
      if (cmd.store) begin
        if (full_w) begin
          dropped_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.scan_clr) begin
        rd_idx_r <= '0;
        best_vld_r <= 1'b0;
      end else if (cmd.rd_en) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      if (take_cand) begin
        best_vld_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit) begin
        if (final_w) begin
          count_r <= '0;
          dropped_r <= 1'b0;
          done_r <= '0;
          placed_r <= '0;
          run_r <= '0;
        end else begin
          done_r[best_idx_r] <= 1'b1;
          placed_r <= placed_r + CW'(1);
          run_r <= end_w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      cmp_idx_r <= rd_idx_r[AW-1:0];
    end
    if (take_cand) begin
      best_key_r <= cand_key;
      best_idx_r <= cmp_idx_r;
      best_align_r <= c_align;
      best_bytes_r <= c_bytes;
    end
    if (cmd.align) begin
      start_r <= start_nxt;
    end
    if (cmd.emit) begin
      out_arrival_index <= 6'(best_idx_r);
      out_start_offset <= start_r;
      out_total_size <= final_w ? end_w : 40'd0;
      out_overflow <= dropped_r;
      out_final_res <= final_w;
    end
  end

  assign status.scan_end = (rd_idx_r == count_r - CW'(1));
  assign status.place_end = final_w;
  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result loaded while the previous beat is still held");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SECTIONS))
    else $error("section count above capacity");

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && final_w) |=> (count_r == '0 && !dropped_r && done_r == '0))
    else $error("run state not cleared after the final result");

  a_align_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.align |-> best_vld_r)
    else $error("alignment started without a selected section");

endmodule

>>> rtl/core/section_sort_and_place.sv
// Top level of the section sort and place block.
//
// Section descriptors arrive on the in_ channel, one beat per cycle, and are
// stored until a beat with in_last high closes the set. Beats beyond
// MAX_SECTIONS are dropped and reported through out_overflow on every result.
// After the last beat the block stops accepting input and emits one out_ beat
// per stored section in placement order, each with its aligned start offset.
// The final result carries out_final_res and the end of the placed region in
// out_total_size; other results show a total of zero.
// For each result, a selection scan reads the section store once per entry
// through its single registered read port; then the last compare settles, the
// offset is aligned and the result is loaded into the output register.
// Collection resumes as soon as the final result is loaded into the output
// register. When the receiver stalls, the held beat stays unchanged and the
// next result waits. Reset returns the block to collection with an empty set,
// the section kind set to text and rank ordering disabled. The cfg_ port writes
// the section kind (index 0) and the rank ordering enable (index 1); the user
// must write them only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
module section_sort_and_place
  import ssp_pkg::*;
#(
  parameter int unsigned MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_alignment,
  input  logic [31:0]           in_section_bytes,
  input  logic [31:0]           in_trail_zeros,
  input  logic                  in_has_rank,
  input  logic [15:0]           in_rank_value,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [5:0]            out_arrival_index,
  output logic [39:0]           out_start_offset,
  output logic [39:0]           out_total_size,
  output logic                  out_overflow,
  output logic                  out_final_res
);

  ssp_cmd_t    cmd;
  ssp_status_t status;

  ssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ssp_dpath #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_alignment      (in_alignment),
    .in_section_bytes  (in_section_bytes),
    .in_trail_zeros    (in_trail_zeros),
    .in_has_rank       (in_has_rank),
    .in_rank_value     (in_rank_value),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_arrival_index (out_arrival_index),
    .out_start_offset  (out_start_offset),
    .out_total_size    (out_total_size),
    .out_overflow      (out_overflow),
    .out_final_res     (out_final_res)
  );

endmodule

>>> test/section_sort_and_place_test.sv
// Self-checking testbench for the section sort and place block.
`timescale 1ns / 1ps
module section_sort_and_place_test;
  import ssp_pkg::*;

  localparam int unsigned SECTION_CAP = MAX_SECTIONS_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_BEATS = 30;
  localparam logic [1:0] KIND_BSS = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [31:0] alignment;
    logic [31:0] size_bytes;
    logic [31:0] trail_zeros;
    logic        has_rank;
    logic [15:0] rank;
    logic        last;
  } section_beat_t;

  typedef struct packed {
    logic [5:0]  arrival;
    logic [39:0] start;
    logic [39:0] total;
    logic        overflow;
    logic        final_res;
  } placement_t;

  typedef enum logic {ROW_SETTING, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [1:0]    sec_kind;
    logic [1:0]    rank_word;
    section_beat_t beat;
    logic          typed;
    placement_t    want;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [31:0]           in_alignment;
  logic [31:0]           in_section_bytes;
  logic [31:0]           in_trail_zeros;
  logic                  in_has_rank;
  logic [15:0]           in_rank_value;
  logic                  in_last;
  logic                  out_valid;
  logic                  out_stall;
  logic [5:0]            out_arrival_index;
  logic [39:0]           out_start_offset;
  logic [39:0]           out_total_size;
  logic                  out_overflow;
  logic                  out_final_res;

  section_sort_and_place u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_alignment      (in_alignment),
    .in_section_bytes  (in_section_bytes),
    .in_trail_zeros    (in_trail_zeros),
    .in_has_rank       (in_has_rank),
    .in_rank_value     (in_rank_value),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_arrival_index (out_arrival_index),
    .out_start_offset  (out_start_offset),
    .out_total_size    (out_total_size),
    .out_overflow      (out_overflow),
    .out_final_res     (out_final_res)
  );

  logic [31:0] held_align [SECTION_CAP];
  logic [31:0] held_bytes [SECTION_CAP];
  logic [31:0] held_tail [SECTION_CAP];
  logic [16:0] held_rank [SECTION_CAP];
  int unsigned held_count;
  bit          held_dropped;
  logic [1:0]  model_kind;
  logic        model_rank_en;

  placement_t  pending_places [$];
  bit          calm;
  int unsigned beats_sent;
  int unsigned sets_placed;
  int unsigned settings_applied;
  int unsigned results_checked;
  int unsigned mismatches;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic section_beat_t mk_beat(logic [31:0] a, logic [31:0] b, logic [31:0] z,
                                            logic hr, logic [15:0] r, logic l);
    section_beat_t s;
    s.alignment = a;
    s.size_bytes = b;
    s.trail_zeros = z;
    s.has_rank = hr;
    s.rank = r;
    s.last = l;
    return s;
  endfunction

  function automatic script_row_t beat_row(section_beat_t b);
    script_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.beat = b;
    return row;
  endfunction

  function automatic script_row_t typed_row(section_beat_t b, logic [39:0] total);
    script_row_t row;
    row = beat_row(b);
    row.typed = 1'b1;
    row.want = '{arrival: 6'd0, start: 40'd0, total: total, overflow: 1'b0, final_res: 1'b1};
    return row;
  endfunction

  function automatic script_row_t setting_row(logic [1:0] k, logic [1:0] rw);
    script_row_t row;
    row = '0;
    row.kind = ROW_SETTING;
    row.sec_kind = k;
    row.rank_word = rw;
    return row;
  endfunction

  function automatic section_beat_t random_section(logic last);
    section_beat_t b;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) b.alignment = 32'd1 << $urandom_range(0, 5);
    else if (r < 7) b.alignment = 32'd0;
    else if (r < 9) b.alignment = 32'd1 << $urandom_range(0, 31);
    else b.alignment = $urandom();
    r = $urandom_range(0, 9);
    if (r < 6) b.size_bytes = $urandom_range(0, 64);
    else if (r < 8) b.size_bytes = $urandom_range(0, 4096);
    else if (r < 9) b.size_bytes = 32'hFFFF_FFFF;
    else b.size_bytes = $urandom();
    b.trail_zeros = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom();
    b.has_rank = 1'($urandom_range(0, 1));
    b.rank = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3)) :
                                           16'($urandom_range(0, 65535));
    b.last = last;
    return b;
  endfunction

  function automatic bit places_ahead(int unsigned a, int unsigned b);
    if (model_kind == KIND_TEXT && model_rank_en) begin
      if (held_rank[a][16] != held_rank[b][16]) return held_rank[a][16];
      if (held_rank[a][16] && held_rank[a][15:0] != held_rank[b][15:0])
        return held_rank[a][15:0] < held_rank[b][15:0];
    end
    if (held_align[a] != held_align[b]) return held_align[a] > held_align[b];
    if (model_kind == KIND_DATA && held_tail[a] != held_tail[b])
      return held_tail[a] < held_tail[b];
    if (held_bytes[a] != held_bytes[b]) return held_bytes[a] > held_bytes[b];
    return a < b;
  endfunction

  function automatic logic [39:0] round_up(logic [39:0] x, logic [31:0] a);
    logic [39:0] m;
    if (a <= 32'd1) return x;
    m = {8'd0, a} - 40'd1;
    return (x + m) & ~m;
  endfunction

  task automatic record_section(section_beat_t b);
    int unsigned order [SECTION_CAP];
    int unsigned n, i, j, e;
    logic [39:0] pos;
    placement_t p;
    if (held_count < SECTION_CAP) begin
      held_align[held_count] = b.alignment;
      held_bytes[held_count] = b.size_bytes;
      held_tail[held_count] = b.trail_zeros;
      held_rank[held_count] = {b.has_rank, b.rank};
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!b.last) return;
    n = held_count;
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && places_ahead(i, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    pos = 40'd0;
    for (i = 0; i < n; i++) begin
      e = order[i];
      pos = round_up(pos, held_align[e]);
      p.arrival = 6'(e);
      p.start = pos;
      pos = pos + {8'd0, held_bytes[e]};
      p.total = (i + 1 == n) ? pos : 40'd0;
      p.overflow = held_dropped;
      p.final_res = (i + 1 == n);
      pending_places.push_back(p);
    end
    held_count = 0;
    held_dropped = 1'b0;
    sets_placed++;
  endtask

  task automatic send_beat(section_beat_t b);
    int unsigned pause;
    pause = pick_pause();
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_alignment <= b.alignment;
    in_section_bytes <= b.size_bytes;
    in_trail_zeros <= b.trail_zeros;
    in_has_rank <= b.has_rank;
    in_rank_value <= b.rank;
    in_last <= b.last;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_set(int unsigned n);
    section_beat_t b;
    int unsigned k;
    for (k = 0; k < n; k++) begin
      b = random_section(k + 1 == n);
      send_beat(b);
      record_section(b);
    end
  endtask

  task automatic apply_setting(logic [1:0] k, logic [1:0] rw, bit stray);
    in_valid <= 1'b0;
    while (pending_places.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SECTION_KIND;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_index <= CFG_RANK_ORDER;
    cfg_wdata <= rw;
    @(posedge clk);
    if (stray) begin
      cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
      cfg_wdata <= 2'($urandom_range(0, 3));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    model_kind = k;
    model_rank_en = rw[0];
    settings_applied++;
  endtask

  task automatic check_field(string label, logic [39:0] want, logic [39:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  initial begin
    int unsigned pause, hold;
    forever begin
      hold = pick_pause();
      out_stall <= (hold != 0);
      pause = (hold != 0) ? hold : $urandom_range(1, 6);
      repeat (pause) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_places.size() == 0) begin
        $display("%0t: result beat with nothing expected, arrival %0d", $time,
                 out_arrival_index);
        mismatches++;
      end else begin
        want = pending_places.pop_front();
        check_field("arrival_index", {34'd0, want.arrival}, {34'd0, out_arrival_index});
        check_field("start_offset", want.start, out_start_offset);
        check_field("total_size", want.total, out_total_size);
        check_field("overflow", {39'd0, want.overflow}, {39'd0, out_overflow});
        check_field("final_res", {39'd0, want.final_res}, {39'd0, out_final_res});
        results_checked++;
      end
    end
  end

  initial begin
    script_row_t script [$];
    script_row_t row;
    int unsigned ph, budget;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SECTION_KIND;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_alignment <= '0;
    in_section_bytes <= '0;
    in_trail_zeros <= '0;
    in_has_rank <= 1'b0;
    in_rank_value <= '0;
    in_last <= 1'b0;
    calm = 1'b0;
    held_count = 0;
    held_dropped = 1'b0;
    model_kind = KIND_TEXT;
    model_rank_en = 1'b0;
    beats_sent = 0;
    sets_placed = 0;
    settings_applied = 0;
    results_checked = 0;
    mismatches = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    script.push_back(typed_row(mk_beat(32'd0, 32'd0, 32'd0, 1'b0, 16'd0, 1'b1), 40'd0));
    script.push_back(typed_row(mk_beat(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                       16'hFFFF, 1'b1), 40'hFFFF_FFFF));
    script.push_back(typed_row(mk_beat(32'd1, 32'd1, 32'd7, 1'b0, 16'd3, 1'b1), 40'd1));
    script.push_back(beat_row(mk_beat(32'd4, 32'd3, 32'd0, 1'b1, 16'd5, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd16, 32'd5, 32'd0, 1'b0, 16'd0, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd0, 32'd7, 32'd0, 1'b1, 16'd1, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd16, 32'd5, 32'd0, 1'b0, 16'd0, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd1, 32'd100, 32'd0, 1'b0, 16'd0, 1'b1)));
    script.push_back(setting_row(KIND_TEXT, 2'b01));
    script.push_back(beat_row(mk_beat(32'd8, 32'd10, 32'd0, 1'b0, 16'd0, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd2, 32'd4, 32'd0, 1'b1, 16'd7, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd64, 32'd4, 32'd0, 1'b1, 16'd7, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd4, 32'd9, 32'd0, 1'b1, 16'd2, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd32, 32'd1, 32'd0, 1'b1, 16'hFFFF, 1'b1)));
    script.push_back(setting_row(KIND_DATA, 2'b01));
    script.push_back(beat_row(mk_beat(32'd8, 32'd20, 32'd5, 1'b1, 16'd0, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd8, 32'd20, 32'd2, 1'b0, 16'd0, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd8, 32'd30, 32'd2, 1'b0, 16'd0, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd8, 32'd20, 32'd5, 1'b0, 16'd0, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd2, 32'd3, 32'd0, 1'b1, 16'd0, 1'b1)));
    script.push_back(setting_row(KIND_BSS, 2'b00));
    script.push_back(beat_row(mk_beat(32'd3, 32'd5, 32'd0, 1'b0, 16'd0, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd12, 32'd7, 32'd0, 1'b0, 16'd0, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd3, 32'd1, 32'd9, 1'b0, 16'd0, 1'b1)));
    script.push_back(setting_row(KIND_SPARE, 2'b11));
    script.push_back(beat_row(mk_beat(32'd4, 32'd6, 32'd9, 1'b1, 16'd1, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd4, 32'd6, 32'd1, 1'b0, 16'd0, 1'b0)));
    script.push_back(beat_row(mk_beat(32'd4, 32'd6, 32'd5, 1'b1, 16'd0, 1'b1)));

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_SETTING) begin
        apply_setting(row.sec_kind, row.rank_word, 1'b0);
      end else begin
        send_beat(row.beat);
        if (row.typed) begin
          pending_places.push_back(row.want);
          sets_placed++;
        end else begin
          record_section(row.beat);
        end
      end
    end

    budget = beats_sent + RANDOM_BEATS;
    for (ph = 0; beats_sent < budget; ph++) begin
      case (ph)
        0: apply_setting(KIND_TEXT, 2'b00, 1'b0);
        1: apply_setting(KIND_TEXT, 2'b01, 1'b0);
        2: apply_setting(KIND_DATA, 2'b10, 1'b1);
        3: apply_setting(KIND_DATA, 2'b01, 1'b0);
        4: apply_setting(KIND_BSS, 2'b11, 1'b0);
        5: apply_setting(KIND_SPARE, 2'b00, 1'b0);
        default: apply_setting(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               $urandom_range(0, 7) == 0);
      endcase
      calm = (ph % 4 == 3);
      repeat ($urandom_range(2, 4)) begin
        hold_size: begin
          int unsigned r;
          r = $urandom_range(0, 9);
          if (r < 7) send_set($urandom_range(1, 6));
          else if (r < 9) send_set($urandom_range(7, 16));
          else send_set($urandom_range(17, 30));
        end
      end
    end

    calm = 1'b0;
    apply_setting(KIND_DATA, 2'b00, 1'b0);
    send_set(SECTION_CAP + $urandom_range(1, 3));

    in_valid <= 1'b0;
    while (pending_places.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    $display("Sent %0d section beats in %0d sets over %0d register settings,", beats_sent,
             sets_placed, settings_applied);
    $display("including one set past capacity; %0d placements checked, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
